// ===== rtl/cache_tag_lookup_lfu_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the cache tag lookup block
// Immediate-style wrappers around concurrent properties clocked on clk.
// ----------------------------------------------------------------------------
`ifndef CACHE_TAG_LOOKUP_LFU_MACROS_SVH
`define CACHE_TAG_LOOKUP_LFU_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define CTLU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define CTLU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CTLU_ASSERT_IMP(label, ante, cons, msg)
`define CTLU_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

// ===== rtl/ctlu_pkg.sv =====
// ----------------------------------------------------------------------------
// ctlu_pkg
// Shared constants and types for the cache tag lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package ctlu_pkg;

    localparam int ADDR_WIDTH  = 16;
    localparam int OFFSET_BITS = 2;
    localparam int NUM_LINES   = 16;
    localparam int WAYS        = 2;
    localparam int COUNT_BITS  = 16;
    localparam int OUT_LINE_BITS = 4;

    localparam int SETS       = NUM_LINES / WAYS;
    localparam int ROW_BITS   = $clog2(SETS);
    localparam int LINE_BITS  = ROW_BITS + 1;
    localparam int BLOCK_BITS = ADDR_WIDTH - OFFSET_BITS;
    // set-associative tag is the widest one
    localparam int TAG_BITS   = BLOCK_BITS - ROW_BITS;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_LOOKUP
    } ctlu_state_t;

    typedef struct packed {
        logic load;
        logic lookup;
    } ctlu_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/ctlu_ctrl.sv =====
// ----------------------------------------------------------------------------
// ctlu_ctrl
// Controller: accepts a request and sequences the tag lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module ctlu_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    output ctlu_pkg::ctlu_cmd_t    cmd
);
    import ctlu_pkg::*;

    ctlu_state_t state_reg;
    ctlu_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.lookup = 1'b0;
        busy       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                busy       = 1'b1;
                cmd.lookup = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/ctlu_datapath.sv =====
// ----------------------------------------------------------------------------
// ctlu_datapath
// Tag, valid and hit-count store in two way banks, compare and LFU fill.
// ----------------------------------------------------------------------------
`default_nettype none

module ctlu_datapath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire ctlu_pkg::ctlu_cmd_t                cmd,
    input  wire logic [ctlu_pkg::ADDR_WIDTH-1:0]    address,
    input  wire logic                               cfg_write,
    input  wire logic                               cfg_data,
    output logic                                    result_valid,
    output logic                                    hit,
    output logic                                    replaced,
    output logic [ctlu_pkg::OUT_LINE_BITS-1:0]      line_used
);
    import ctlu_pkg::*;

    logic [ADDR_WIDTH-1:0] addr_reg;
    logic                  mode_reg;

    // line index = {row, way}: way 0 and way 1 live in separate banks
    logic [TAG_BITS-1:0]   tag_mem   [WAYS][SETS];
    logic [COUNT_BITS-1:0] count_mem [WAYS][SETS];
    logic [SETS-1:0]       valid_reg [WAYS];

    logic                  result_valid_reg;
    logic                  hit_reg;
    logic [LINE_BITS-1:0]  line_reg;

    logic [BLOCK_BITS-1:0] block;
    logic [ROW_BITS-1:0]   row;
    logic [TAG_BITS-1:0]   tag_cmp;
    logic [WAYS-1:0]       way_en;
    logic [WAYS-1:0]       match;
    logic [COUNT_BITS-1:0] count_rd [WAYS];
    logic                  any_hit;
    logic                  hit_way;
    logic                  victim_way;
    logic                  way_sel;
    logic [COUNT_BITS-1:0] count_sel;
    logic [COUNT_BITS-1:0] count_inc;

    assign block = addr_reg[ADDR_WIDTH-1:OFFSET_BITS];

    always_comb
    begin
        if (mode_reg)
        begin
            row     = block[ROW_BITS:1];
            tag_cmp = {1'b0, block[BLOCK_BITS-1:LINE_BITS]};
            way_en  = '0;
            way_en[block[0]] = 1'b1;
        end
        else
        begin
            row     = block[ROW_BITS-1:0];
            tag_cmp = block[BLOCK_BITS-1:ROW_BITS];
            way_en  = '1;
        end
    end

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            match[w]    = way_en[w] && valid_reg[w][row] && (tag_mem[w][row] == tag_cmp);
            // an unfilled line has never been counted
            count_rd[w] = valid_reg[w][row] ? count_mem[w][row] : '0;
        end
    end

    assign any_hit    = |match;
    assign hit_way    = mode_reg ? block[0] : ~match[0];
    assign victim_way = mode_reg ? block[0] : (count_rd[1] < count_rd[0]);
    assign way_sel    = any_hit ? hit_way : victim_way;
    assign count_sel  = count_rd[way_sel];
    // saturate at all ones
    assign count_inc  = (&count_sel) ? count_sel : count_sel + COUNT_BITS'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            addr_reg <= address;
        end
        if (cmd.lookup)
        begin
            if (any_hit)
            begin
                count_mem[way_sel][row] <= count_inc;
            end
            else
            begin
                tag_mem[way_sel][row]   <= tag_cmp;
                count_mem[way_sel][row] <= '0;
            end
            hit_reg  <= any_hit;
            line_reg <= {row, way_sel};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                valid_reg[w] <= '0;
            end
            mode_reg         <= 1'b1;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.lookup && !any_hit)
            begin
                valid_reg[way_sel][row] <= 1'b1;
            end
            if (cfg_write)
            begin
                mode_reg <= cfg_data;
            end
            result_valid_reg <= cmd.lookup;
        end
    end

    assign result_valid = result_valid_reg;
    assign hit          = hit_reg;
    assign replaced     = ~hit_reg;
    assign line_used    = OUT_LINE_BITS'(line_reg);

endmodule

`default_nettype wire

// ===== rtl/cache_tag_lookup_lfu.sv =====
// ----------------------------------------------------------------------------
// cache_tag_lookup_lfu
// Cache tag store with direct-mapped or two-way LFU set-associative lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive address and raise start; the request is taken at a clock
//   edge where start is high and busy is low. busy stays high for one cycle.
//   Result: result_valid rises from its register after the lookup state and
//   holds hit, replaced and line_used for one cycle; the result is taken at
//   the edge that ends that cycle. The receiver has no backpressure;
//   the result must be taken in that cycle.
//   Requests: a new request is taken once the load/lookup sequence of the
//   controller is idle again, also while a result shows.
//   Set-associative mode compares both ways of a set in the same lookup cycle.
//   Configuration: cfg_data is direct_mapped_mode, written when
//   cfg_valid and cfg_ready are high; cfg_ready is low while busy.
//   Reset: all lines invalid, hit counts treated as zero, direct-mapped
//   mode selected. No clearing pass is needed; valid bits clear at once.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cache_tag_lookup_lfu_macros.svh"

module cache_tag_lookup_lfu (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [ctlu_pkg::ADDR_WIDTH-1:0]    address,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic                               cfg_data,
    output logic                                    result_valid,
    output logic                                    hit,
    output logic                                    replaced,
    output logic [ctlu_pkg::OUT_LINE_BITS-1:0]      line_used
);
    import ctlu_pkg::*;

    ctlu_cmd_t cmd;

    ctlu_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    assign cfg_ready = ~busy;

    ctlu_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .address      (address),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .hit          (hit),
        .replaced     (replaced),
        .line_used    (line_used)
    );

    `CTLU_ASSERT_NXT(a_req_busy, cmd.load, busy && cmd.lookup, "request did not start lookup")
    `CTLU_ASSERT_NXT(a_req_result, start && !busy, ##1 result_valid, "result missing after request")
    `CTLU_ASSERT_NXT(a_no_back_result, result_valid, !result_valid, "results back to back")
    `CTLU_ASSERT_IMP(a_lookup_idle, result_valid, !busy, "result while lookup in progress")

endmodule

`default_nettype wire
